// File: rtl/core/twg_pkg.sv
// Package for the twister word generator: sizes, function codes, and the
// twist and tempering functions. It depends on nothing else.
`timescale 1ns / 1ps

package twg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int WORD_W       = 32;
    localparam int INDEX_W      = 10;
    localparam int FUNC_W       = 2;

    localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;
    localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7FFF_FFFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_POS   = 2'd1,
        FUNC_DRAW  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // One step of the twist recurrence.
    function automatic logic [WORD_W-1:0] mix_pair(
        input logic [WORD_W-1:0] hi_word,
        input logic [WORD_W-1:0] lo_word,
        input logic [WORD_W-1:0] lag_word
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = (hi_word & UPPER_BIT) | (lo_word & LOWER_BITS);
        v = lag_word ^ (y >> 1);
        if (y[0]) begin
            v = v ^ MATRIX_A;
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: rtl/core/twg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps

module twg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/twister_word_generator.sv
// Twister word generator: MT19937 state store, regeneration sequencer and
// tempered output. It depends on twg_pkg and twg_ram.
`timescale 1ns / 1ps

// A write or position transfer takes effect at its own edge; with the store current,
// a draw reads its word and loads it tempered into the output register. Throughput:
// writes and position moves one per cycle while idle; a new draw is not taken before
// the last has loaded its word, and a draw waits while the output register is still
// occupied. The draw that finds the position at 624 first regenerates the store,
// paced by the single RAM read port (two reads per word: the next word and the
// lagged word). Reset (synchronous, active low) sets the position to 624 and clears
// the control state; the state store is not cleared and must be loaded in full.

module twister_word_generator
    import twg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata fields, lowest bit up: word_index[9:0], word_value[41:10], zero pad.
    input  logic [47:0]            s_axis_tdata,
    // tuser fields, lowest bit up: func[1:0].
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata fields, lowest bit up: random_word[31:0].
    output logic [WORD_W-1:0]      m_axis_tdata
);

    localparam int AW = $clog2(STATE_WORDS);
    localparam int LAG_WRAP = STATE_WORDS - TWIST_OFFSET;

    localparam logic [INDEX_W-1:0] POS_FULL = INDEX_W'(STATE_WORDS);
    localparam logic [AW-1:0] LAST_K     = AW'(STATE_WORDS - 1);
    localparam logic [AW-1:0] PRELAST_K  = AW'(STATE_WORDS - 2);
    localparam logic [AW-1:0] LAG_WRAP_K = AW'(LAG_WRAP);
    localparam logic [AW-1:0] OFFSET_K   = AW'(TWIST_OFFSET);

    // Sequencer states. Regeneration loops RD_LAG -> MIX once per word: RD_LAG
    // captures the next word and asks for the lagged word, MIX writes the new
    // word back and asks for the next word of the following step.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_RD_LAG,
        ST_MIX,
        ST_DRAW_RD,
        ST_DRAW_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [INDEX_W-1:0]  r_position, n_position;
    logic [AW-1:0]       r_k, n_k;
    logic [WORD_W-1:0]   r_cur, n_cur;
    logic [WORD_W-1:0]   r_nxt, n_nxt;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_data, n_out_data;

    logic                in_xfer;
    t_func               in_func;
    logic [INDEX_W-1:0]  in_index;
    logic [WORD_W-1:0]   in_value;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [WORD_W-1:0]   rd_data;

    logic [AW-1:0]       lag_addr;
    logic [AW-1:0]       next2_addr;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign in_func  = t_func'(s_axis_tuser);
    assign in_index = s_axis_tdata[INDEX_W-1:0];
    assign in_value = s_axis_tdata[INDEX_W +: WORD_W];

    // Lagged index (k + 397) mod 624. For k at or above 227 the lagged word has
    // already been rewritten in this pass, which is what the recurrence wants.
    assign lag_addr = (r_k < LAG_WRAP_K) ? (r_k + OFFSET_K) : (r_k - LAG_WRAP_K);

    // Next index of the following step, (k + 2) mod 624. The last step pairs
    // with word 0, read back after its rewrite.
    assign next2_addr = (r_k == PRELAST_K) ? '0 : (r_k + AW'(2));

    twg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_position  = r_position;
        n_k         = r_k;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_addr     = r_k;
        wr_data     = mix_pair(r_cur, r_nxt, rd_data);
        rd_en       = 1'b1;
        rd_addr     = r_position[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (in_func)
                        FUNC_WRITE: begin
                            // A write beyond the store is dropped.
                            wr_en   = (in_index < POS_FULL);
                            wr_addr = in_index[AW-1:0];
                            wr_data = in_value;
                        end
                        FUNC_POS: begin
                            n_position = (in_index > POS_FULL) ? POS_FULL : in_index;
                        end
                        FUNC_DRAW: begin
                            if (r_position >= POS_FULL) begin
                                // Store exhausted: fetch word 0 and start a pass.
                                rd_addr    = '0;
                                n_k        = '0;
                                n_position = '0;
                                n_state    = ST_LOAD0;
                            end else begin
                                n_state = ST_DRAW_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD0: begin
                n_cur   = rd_data;
                rd_addr = r_k + AW'(1);
                n_state = ST_RD_LAG;
            end
            ST_RD_LAG: begin
                n_nxt   = rd_data;
                rd_addr = lag_addr;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                wr_en = 1'b1;
                n_cur = r_nxt;
                if (r_k == LAST_K) begin
                    n_state = ST_DRAW_RD;
                end else begin
                    n_k     = r_k + AW'(1);
                    rd_addr = next2_addr;
                    n_state = ST_RD_LAG;
                end
            end
            ST_DRAW_RD: begin
                n_state = ST_DRAW_OUT;
            end
            ST_DRAW_OUT: begin
                // Hold the read data while the output register is occupied.
                rd_en = 1'b0;
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = temper(rd_data);
                    n_position  = r_position + INDEX_W'(1);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_position  <= POS_FULL;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_position  <= n_position;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= POS_FULL)
        else $error("read position beyond the store");

    a_mix_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX) |-> (rd_addr != wr_addr))
        else $error("regeneration reads the word it writes");

    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX && r_k == LAST_K) |=> (r_state == ST_DRAW_RD && r_position == '0))
        else $error("regeneration pass did not end at position zero");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DRAW_OUT))
        else $error("result loaded outside the draw state");

    a_pass_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX && r_k != LAST_K)
            |=> (r_state == ST_RD_LAG && r_k == $past(r_k) + AW'(1)))
        else $error("regeneration step count slipped");
`endif

endmodule

// File: sim/twg_word_checker.sv
// Checker for the twister word generator: watches both stream channels, keeps
// its own copy of the state store and read position, and compares every output word.
// It depends on twg_pkg for sizes, function codes and the twist and tempering constants.
`timescale 1ns / 1ps

module twg_word_checker
    import twg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    // tdata fields, lowest bit up: word_index[9:0], word_value[41:10], zero pad.
    input  logic [47:0]         s_axis_tdata,
    // tuser fields, lowest bit up: func[1:0].
    input  logic [FUNC_W-1:0]   s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata fields, lowest bit up: random_word[31:0].
    input  logic [WORD_W-1:0]   m_axis_tdata,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [WORD_W-1:0]  store_words [STATE_WORDS];
    int                 draw_pos;
    logic [WORD_W-1:0]  expected_words [$];
    logic [INDEX_W-1:0] in_index;
    logic [WORD_W-1:0]  in_value;
    logic [WORD_W-1:0]  want_word;
    int                 fail_count = 0;
    int                 pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur_word,
        input logic [WORD_W-1:0] next_word,
        input logic [WORD_W-1:0] lag_word
    );
        logic [WORD_W-1:0] joined;
        joined = {cur_word[WORD_W-1], next_word[WORD_W-2:0]};
        return lag_word ^ (joined >> 1) ^ (joined[0] ? MATRIX_A : '0);
    endfunction

    function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] t;
        t = raw ^ (raw >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        return t ^ (t >> 18);
    endfunction

    // The store is rebuilt in place, so late words see already updated neighbors.
    task automatic refill_store();
        int next_k;
        int lag_k;
        for (int k = 0; k < STATE_WORDS; k++) begin
            next_k = (k + 1) % STATE_WORDS;
            lag_k  = (k + TWIST_OFFSET) % STATE_WORDS;
            store_words[k[INDEX_W-1:0]] = twist_word(store_words[k[INDEX_W-1:0]],
                                                     store_words[next_k[INDEX_W-1:0]],
                                                     store_words[lag_k[INDEX_W-1:0]]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            draw_pos = STATE_WORDS;
            expected_words.delete();
        end else begin
            // An output word can never belong to a draw taken at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected random_word, expected none, actual %08h",
                             $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want_word = expected_words.pop_front();
                    if (want_word !== m_axis_tdata) begin
                        $display("%0t: random_word mismatch, expected %08h, actual %08h",
                                 $time, want_word, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_index = s_axis_tdata[INDEX_W-1:0];
                in_value = s_axis_tdata[INDEX_W +: WORD_W];
                case (t_func'(s_axis_tuser))
                    FUNC_WRITE: begin
                        if (in_index < STATE_WORDS) begin
                            store_words[in_index] = in_value;
                        end
                    end
                    FUNC_POS: begin
                        draw_pos = (in_index > STATE_WORDS) ? STATE_WORDS : in_index;
                    end
                    FUNC_DRAW: begin
                        if (draw_pos >= STATE_WORDS) begin
                            refill_store();
                            draw_pos = 0;
                        end
                        expected_words.push_back(
                            tempered(store_words[draw_pos[INDEX_W-1:0]]));
                        draw_pos++;
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending = expected_words.size();
    end

endmodule

// File: sim/tb.sv
// Top of the twister word generator testbench: clock, reset, stimulus, output
// back-pressure and the verdict. It depends on twg_pkg, twg_word_checker and the block.
`timescale 1ns / 1ps

module tb;
    import twg_pkg::*;

    // Number of random items after the store load and the directed items.
    localparam int RANDOM_ITEMS    = 800;
    // The final stretch of random items runs with no idling on either side.
    localparam int QUIET_ITEMS     = 150;
    // After this many output transfers the receiver holds off for a long stretch.
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    // The limit leaves a wide margin over a regeneration pass plus the long hold-off
    // and the longest idle bursts.
    localparam int STALL_LIMIT     = 20000;
    // Cycles left after the last expected word, for the block to settle.
    localparam int DRAIN_CYCLES    = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // tdata fields, lowest bit up: word_index[9:0], word_value[41:10], zero pad.
    logic [47:0]        s_axis_tdata;
    // tuser fields, lowest bit up: func[1:0].
    logic [FUNC_W-1:0]  s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // tdata fields, lowest bit up: random_word[31:0].
    logic [WORD_W-1:0]  m_axis_tdata;

    int fail_count;
    int words_pending;
    int items_sent    = 0;
    int results_taken = 0;
    int stall_cycles  = 0;
    bit quiet         = 1'b0;
    bit held_off      = 1'b0;

    twister_word_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    twg_word_checker u_word_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Output transfers are counted so that the receiver knows when to hold off.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_taken <= results_taken + 1;
        end
    end

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (stall_cycles < STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Offers one item and waits for its transfer. Before the item the sender may
    // idle for a random burst; every third stretch of 90 items has no idling, and
    // neither has the final quiet stretch. Inputs change at the falling edge only,
    // and tready is read right after the rising edge, before the block updates it.
    task automatic send_item(
        input t_func              func,
        input logic [INDEX_W-1:0] index,
        input logic [WORD_W-1:0]  value
    );
        int gap;
        gap = 0;
        if (!quiet && ((items_sent / 90) % 3 != 2) && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {6'd0, value, index};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Receiver: random stall bursts, one long hold-off while the sender keeps
    // offering items so that the block fills up, and no stalls in the quiet stretch.
    initial begin
        int burst;
        int rx_cycle;
        m_axis_tready = 1'b0;
        rx_cycle = 0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (!held_off && results_taken >= HOLD_OFF_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                held_off = 1'b1;
            end else if (!quiet && ((rx_cycle / 300) % 4 != 3) && $urandom_range(0, 6) == 0) begin
                burst = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int                 pick;
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  value;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_NONE;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The whole store must hold written words before the first draw. The
        // first and last words get the extreme values.
        for (int k = 0; k < STATE_WORDS; k++) begin
            if (k == 0) begin
                value = '0;
            end else if (k == STATE_WORDS - 1) begin
                value = '1;
            end else if (k == 1) begin
                value = 32'h8000_0001;
            end else begin
                value = $urandom;
            end
            send_item(FUNC_WRITE, k[INDEX_W-1:0], value);
        end

        // Directed items. The position comes out of reset at the end of the
        // store, so the first draw regenerates it.
        send_item(FUNC_DRAW, '0, '0);
        send_item(FUNC_DRAW, '0, '0);
        // The unused function code must leave the position alone.
        send_item(FUNC_NONE, '1, '1);
        send_item(FUNC_DRAW, '0, '0);
        // Writes past the end of the store are dropped.
        send_item(FUNC_WRITE, INDEX_W'(STATE_WORDS), '1);
        send_item(FUNC_WRITE, '1, '1);
        // Words written after a regeneration come out tempered as they are.
        send_item(FUNC_WRITE, 10'd5, '0);
        send_item(FUNC_WRITE, 10'd6, '1);
        send_item(FUNC_POS, 10'd5, '0);
        send_item(FUNC_DRAW, '0, '0);
        send_item(FUNC_DRAW, '0, '0);
        send_item(FUNC_POS, '0, '1);
        send_item(FUNC_DRAW, '0, '0);
        // Last word, then running off the end into a regeneration.
        send_item(FUNC_POS, INDEX_W'(STATE_WORDS - 1), '0);
        send_item(FUNC_DRAW, '0, '0);
        send_item(FUNC_DRAW, '0, '0);
        // Positions at and above the end of the store force a regeneration; position 512 does not.
        send_item(FUNC_POS, INDEX_W'(STATE_WORDS), '0);
        send_item(FUNC_DRAW, '0, '0);
        send_item(FUNC_POS, INDEX_W'(STATE_WORDS + 1), '0);
        send_item(FUNC_DRAW, '0, '0);
        send_item(FUNC_POS, '1, '0);
        send_item(FUNC_DRAW, '1, '1);
        send_item(FUNC_POS, 10'd512, '0);
        send_item(FUNC_DRAW, '0, '0);

        // Random part: mostly draws, mixed with store writes, position moves
        // (some out of range) and items with the unused function code.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            pick  = $urandom_range(0, 99);
            value = $urandom;
            index = INDEX_W'($urandom_range(0, 1023));
            if (pick < 72) begin
                send_item(FUNC_DRAW, index, value);
            end else if (pick < 84) begin
                if ($urandom_range(0, 9) != 0) begin
                    index = INDEX_W'($urandom_range(0, STATE_WORDS - 1));
                end else begin
                    index = INDEX_W'($urandom_range(STATE_WORDS, 1023));
                end
                case ($urandom_range(0, 7))
                    0: value = '0;
                    1: value = '1;
                    default: begin
                    end
                endcase
                send_item(FUNC_WRITE, index, value);
            end else if (pick < 93) begin
                if ($urandom_range(0, 3) != 0) begin
                    index = INDEX_W'($urandom_range(0, STATE_WORDS - 1));
                end else begin
                    index = INDEX_W'($urandom_range(600, 1023));
                end
                send_item(FUNC_POS, index, value);
            end else begin
                send_item(FUNC_NONE, index, value);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Wait for every expected word, then let the block settle.
        while (words_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: twister_word_generator.f
rtl/core/twg_pkg.sv
rtl/core/twg_ram.sv
rtl/core/twister_word_generator.sv
sim/twg_word_checker.sv
sim/tb.sv
